// File: design/kvt_pkg.sv
// kvt_pkg: shared types and constants for the key-value table.
// Holds request and result codes, controller states and the
// command/status structs between controller and datapath.
package kvt_pkg;

	localparam int KEY_W   = 32;
	localparam int VALIO_W = 32;
	localparam int CNTO_W  = 5;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_FIND   = 2'd1,
		MODE_DELETE = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_DUP     = 2'd1,
		ST_MISSING = 2'd2,
		ST_FULL    = 2'd3
	} res_code_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_SHIFT,
		S_FINISH
	} fsm_state_t;

	typedef struct packed {
		logic      load_req;    // latch request, restart walk
		logic      walk;        // issue next read while pointer below count
		logic      shift_start; // begin gap close after matched entry
		logic      shift_wr;    // write returning read data one slot down
		logic      append;      // store request pair at end, count up
		logic      dec_cnt;     // count down after gap close
		logic      set_result;
		res_code_t res_code;
		logic      res_use_value;
		logic      load_out;    // move result into output register
	} ctrl_cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  hit;       // read data matches request key
		logic  exhausted; // no read in flight and none left to issue
		logic  full;
	} dp_stat_t;

endpackage

// File: design/kvt_ram.sv
// kvt_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
module kvt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: design/kvt_dp.sv
// kvt_dp: datapath of the key-value table: request registers, entry
// count, walk pointer, key compare, table RAM and output registers.
// Depends on kvt_pkg and kvt_ram.
module kvt_dp #(
	parameter int CAPACITY   = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  kvt_pkg::ctrl_cmd_t         cmd,
	input  logic [1:0]                 mode,
	input  logic [kvt_pkg::KEY_W-1:0]  key,
	input  logic [kvt_pkg::VALIO_W-1:0] value_in,
	output kvt_pkg::dp_stat_t          stat,
	output logic [1:0]                 status,
	output logic [kvt_pkg::VALIO_W-1:0] value_out,
	output logic [kvt_pkg::CNTO_W-1:0] entry_count
);
	import kvt_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int DW = KEY_W + VALUE_BITS;

	mode_t                req_mode_q;
	logic [KEY_W-1:0]     req_key_q;
	logic [VALUE_BITS-1:0] req_val_q;
	logic [CW-1:0]        cnt_q;
	logic [CW-1:0]        ptr_q;
	logic                 pend_s1;
	logic [CW-1:0]        pidx_s1;
	res_code_t            res_code_q;
	logic [VALIO_W-1:0]   res_val_q;

	logic                 issue;
	logic [DW-1:0]        rd_data;
	logic [KEY_W-1:0]     rd_key;
	logic [VALUE_BITS-1:0] rd_val;
	logic                 we;
	logic [AW-1:0]        waddr;
	logic [DW-1:0]        wdata;
	logic [CW-1:0]        wdest;

	assign issue  = cmd.walk && (ptr_q < cnt_q);
	assign rd_key = rd_data[DW-1 -: KEY_W];
	assign rd_val = rd_data[VALUE_BITS-1:0];
	assign wdest  = pidx_s1 - CW'(1);

	assign we    = cmd.append || (cmd.shift_wr && pend_s1);
	assign waddr = cmd.append ? cnt_q[AW-1:0] : wdest[AW-1:0];
	assign wdata = cmd.append ? {req_key_q, req_val_q} : rd_data;

	assign stat.mode      = req_mode_q;
	assign stat.hit       = pend_s1 && (rd_key == req_key_q);
	assign stat.exhausted = !pend_s1 && (ptr_q >= cnt_q);
	assign stat.full      = (cnt_q >= CW'(CAPACITY));

	kvt_ram #(
		.WIDTH(DW),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(ptr_q[AW-1:0]),
		.rdata(rd_data)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			ptr_q   <= '0;
			pend_s1 <= 1'b0;
		end else begin
			if (cmd.append) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.dec_cnt) begin
				cnt_q <= cnt_q - CW'(1);
			end
			priority if (cmd.load_req) begin
				ptr_q   <= '0;
				pend_s1 <= 1'b0;
			end else if (cmd.shift_start) begin
				// first source is the entry after the match
				ptr_q   <= pidx_s1 + CW'(1);
				pend_s1 <= 1'b0;
			end else begin
				if (issue) begin
					ptr_q <= ptr_q + CW'(1);
				end
				pend_s1 <= issue;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_mode_q <= mode_t'(mode);
			req_key_q  <= key;
			req_val_q  <= VALUE_BITS'(value_in);
			res_code_q <= ST_OK;
			res_val_q  <= '0;
		end else if (cmd.set_result) begin
			res_code_q <= cmd.res_code;
			res_val_q  <= cmd.res_use_value ? VALIO_W'(rd_val) : '0;
		end
		if (!cmd.shift_start) begin
			pidx_s1 <= ptr_q;
		end
		if (cmd.load_out) begin
			status      <= res_code_q;
			value_out   <= res_val_q;
			entry_count <= CNTO_W'(cnt_q);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_pend_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (pidx_s1 < cnt_q))
		else $error("read returned for an entry past the count");

	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.append |-> (cnt_q < CW'(CAPACITY)) && !cmd.dec_cnt)
		else $error("append into a full table");

endmodule

// File: design/kvt_ctrl.sv
// kvt_ctrl: controller state machine of the key-value table.
// Sequences search, gap close and result hand-off. Depends on kvt_pkg.
module kvt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  kvt_pkg::dp_stat_t  stat,
	output kvt_pkg::ctrl_cmd_t cmd
);
	import kvt_pkg::*;

	fsm_state_t state_q, state_nxt;
	logic       out_valid_q;

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		cmd.res_code = ST_OK;
		in_stall  = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_nxt    = S_SEARCH;
				end
			end
			S_SEARCH: begin
				if (stat.mode == MODE_NONE) begin
					state_nxt = S_FINISH;
				end else begin
					cmd.walk = 1'b1;
					if (stat.hit) begin
						state_nxt = S_FINISH;
						unique case (stat.mode)
							MODE_INSERT: begin
								cmd.set_result = 1'b1;
								cmd.res_code   = ST_DUP;
							end
							MODE_FIND: begin
								cmd.set_result    = 1'b1;
								cmd.res_use_value = 1'b1;
							end
							MODE_DELETE: begin
								cmd.shift_start = 1'b1;
								state_nxt       = S_SHIFT;
							end
							default: ;
						endcase
					end else if (stat.exhausted) begin
						state_nxt      = S_FINISH;
						cmd.set_result = 1'b1;
						if (stat.mode == MODE_INSERT) begin
							if (stat.full) begin
								cmd.res_code = ST_FULL;
							end else begin
								cmd.append = 1'b1;
							end
						end else begin
							cmd.res_code = ST_MISSING;
						end
					end
				end
			end
			S_SHIFT: begin
				cmd.walk     = 1'b1;
				cmd.shift_wr = 1'b1;
				if (stat.exhausted) begin
					cmd.dec_cnt = 1'b1;
					state_nxt   = S_FINISH;
				end
			end
			S_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH && out_valid_q && out_stall) |=> (state_q == S_FINISH))
		else $error("result overwritten while output stalled");

endmodule

// File: design/key_value_table_linear_search_top.sv
// Search reads one stored entry per cycle from the RAM and compares keys on
// registered read data. A delete hit then closes the gap by walking only the
// later entries. Requests are handled one at a time; the next is taken the
// cycle after the result is loaded, and a stalled earlier result that holds the
// output register delays that load.
// Reset (arst_n low): table empty, output invalid; RAM contents not cleared.
// Depends on kvt_pkg, kvt_ctrl, kvt_dp, kvt_ram.
module key_value_table_linear_search_top #(
	parameter int CAPACITY   = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  mode,
	input  logic signed [kvt_pkg::KEY_W-1:0] key,
	input  logic [kvt_pkg::VALIO_W-1:0] value_in,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  status,
	output logic [kvt_pkg::VALIO_W-1:0] value_out,
	output logic [kvt_pkg::CNTO_W-1:0]  entry_count
);
	import kvt_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	kvt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	kvt_dp #(
		.CAPACITY  (CAPACITY),
		.VALUE_BITS(VALUE_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.mode       (mode),
		.key        (key),
		.value_in   (value_in),
		.stat       (stat),
		.status     (status),
		.value_out  (value_out),
		.entry_count(entry_count)
	);

endmodule

// File: tb/key_value_table_linear_search_top_tb.sv
// Testbench for key_value_table_linear_search_top: directed and random insert/find/delete
// requests, each result checked against a table model kept in the testbench.
// Depends on kvt_pkg and the key_value_table_linear_search_top RTL.
module key_value_table_linear_search_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import kvt_pkg::*;

	localparam int CAPACITY = 16;

	typedef struct packed {
		res_code_t   status;
		logic [31:0] value;
		logic [4:0]  count;
	} kv_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  mode;
	logic [31:0] key;
	logic [31:0] value_in;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [31:0] value_out;
	logic [4:0]  entry_count;

	// table model
	logic [31:0] model_keys [CAPACITY];
	logic [31:0] model_vals [CAPACITY];
	int          stored = 0;

	kv_result_t  pending_results [$];
	int          mismatches = 0;
	bit          gap_enable = 1'b1;
	bit          stall_enable = 1'b1;
	int          stall_left = 0;

	key_value_table_linear_search_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.key        (key),
		.value_in   (value_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.value_out  (value_out),
		.entry_count(entry_count)
	);

	always #6 clk = ~clk;

	initial begin
		#10ms;
		$display("simulation failed");
		$finish;
	end

	function automatic kv_result_t apply_request(logic [1:0] m, logic [31:0] k,
			logic [31:0] v);
		kv_result_t r;
		int pos;
		r.status = ST_OK;
		r.value = '0;
		pos = stored;
		for (int i = 0; i < stored; i++)
			if (pos == stored && model_keys[i] == k)
				pos = i;
		case (m)
			MODE_INSERT: begin
				if (pos < stored)
					r.status = ST_DUP;
				else if (stored >= CAPACITY)
					r.status = ST_FULL;
				else begin
					model_keys[stored] = k;
					model_vals[stored] = v;
					stored++;
				end
			end
			MODE_FIND: begin
				if (pos < stored)
					r.value = model_vals[pos];
				else
					r.status = ST_MISSING;
			end
			MODE_DELETE: begin
				if (pos < stored) begin
					// close the gap, keep insertion order
					for (int i = pos; i + 1 < stored; i++) begin
						model_keys[i] = model_keys[i + 1];
						model_vals[i] = model_vals[i + 1];
					end
					stored--;
				end else
					r.status = ST_MISSING;
			end
			default: ;
		endcase
		r.count = stored[4:0];
		return r;
	endfunction

	task automatic send_request(logic [1:0] m, logic [31:0] k, logic [31:0] v);
		int gap;
		gap = gap_enable ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		key <= k;
		value_in <= v;
		do
			@(posedge clk);
		while (in_stall);
		pending_results.insert(pending_results.size(), apply_request(m, k, v));
	endtask

	function automatic void note_mismatch(string what);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t mismatch: %s", $realtime, what);
	endfunction

	// receiver stall: a fresh wait drawn after every accepted result
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			stall_left = stall_enable ? $urandom_range(0, 3) : 0;
		else if (stall_left > 0)
			stall_left--;
		out_stall <= (stall_left > 0);
	end

	always @(posedge clk) begin
		kv_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0)
				note_mismatch($sformatf("unexpected result status=%0d value=%h count=%0d",
					status, value_out, entry_count));
			else begin
				want = pending_results.pop_front();
				if (status !== want.status || value_out !== want.value ||
						entry_count !== want.count)
					note_mismatch($sformatf(
						"expected status=%0d value=%h count=%0d, got status=%0d value=%h count=%0d",
						want.status, want.value, want.count, status, value_out, entry_count));
			end
		end
	end

	task automatic test_empty_table();
		send_request(MODE_FIND, 32'd5, $urandom());
		send_request(MODE_DELETE, 32'd5, $urandom());
		send_request(MODE_NONE, $urandom(), $urandom());
	endtask

	task automatic test_extremes();
		send_request(MODE_INSERT, 32'h8000_0000, 32'h0000_0000);
		send_request(MODE_INSERT, 32'h7fff_ffff, 32'hffff_ffff);
		send_request(MODE_INSERT, 32'hffff_ffff, 32'ha5a5_a5a5);
		send_request(MODE_INSERT, 32'h0000_0000, 32'h5a5a_5a5a);
		send_request(MODE_INSERT, 32'h7fff_ffff, 32'h1234_5678);
		send_request(MODE_FIND, 32'h7fff_ffff, $urandom());
		send_request(MODE_FIND, 32'hffff_ffff, $urandom());
		// deleting the head shifts the rest down
		send_request(MODE_DELETE, 32'h8000_0000, $urandom());
		send_request(MODE_FIND, 32'h0000_0000, $urandom());
	endtask

	task automatic test_full_table();
		while (stored < CAPACITY)
			send_request(MODE_INSERT, $urandom(), $urandom());
		send_request(MODE_INSERT, 32'h8000_0000, $urandom());
		// duplicate wins over full
		send_request(MODE_INSERT, model_keys[CAPACITY - 1], $urandom());
		send_request(MODE_NONE, $urandom(), $urandom());
	endtask

	task automatic test_random(int n);
		logic [31:0] pool [20];
		int r;
		int insert_weight;
		logic [1:0] m;
		logic [31:0] k;
		for (int i = 0; i < n; i++) begin
			if (i % 200 == 0)
				foreach (pool[j])
					pool[j] = $urandom();
			// alternate fill-heavy and drain-heavy phases
			insert_weight = ((i / 100) % 2 == 0) ? 60 : 20;
			if (i % 150 == 0)
				gap_enable = ((i / 150) % 3 != 1);
			if (i % 170 == 0)
				stall_enable = ((i / 170) % 3 != 2);
			r = $urandom_range(0, 99);
			k = pool[$urandom_range(0, 19)];
			if (r < 3) begin
				m = MODE_NONE;
				k = $urandom();
			end else if (r < 7) begin
				m = 2'($urandom_range(0, 2));
				k = $urandom();
			end else if (r < 7 + insert_weight)
				m = MODE_INSERT;
			else if (r < 7 + insert_weight + (93 - insert_weight) / 2)
				m = MODE_FIND;
			else
				m = MODE_DELETE;
			send_request(m, k, $urandom());
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		mode <= MODE_NONE;
		key <= '0;
		value_in <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_extremes();
		test_full_table();
		test_random(1500);
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: sim.f
design/kvt_pkg.sv
design/kvt_ram.sv
design/kvt_dp.sv
design/kvt_ctrl.sv
design/key_value_table_linear_search_top.sv
tb/key_value_table_linear_search_top_tb.sv
